/* rtl/double_ended_queue_with_search_macros.svh */
// Assertion macros used by the deque datapath (deqs_dp).
// Needs nothing else; each macro checks on the rising clock edge and is off while in reset.
`ifndef DOUBLE_ENDED_QUEUE_WITH_SEARCH_MACROS_SVH
`define DOUBLE_ENDED_QUEUE_WITH_SEARCH_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DEQS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define DEQS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/deqs_pkg.sv */
// Types, constants and address helpers for the double-ended queue.
// Used by the controller, the datapath and the top level; depends on nothing.
package deqs_pkg;

	localparam int DEPTH = 64;
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = 7;
	localparam int SW = ((AW > CNT_W) ? AW : CNT_W) + 1;
	localparam int KEY_W = 32;
	localparam int PADDR_W = 3;

	localparam logic [PADDR_W-1:0] ADDR_CAPACITY = PADDR_W'(0);
	localparam logic [CNT_W-1:0] CAPACITY_RESET = CNT_W'(64);

	typedef enum logic [2:0] {
		OP_PUSH_FRONT = 3'd0,
		OP_PUSH_BACK  = 3'd1,
		OP_POP_FRONT  = 3'd2,
		OP_POP_BACK   = 3'd3,
		OP_SEARCH     = 3'd4
	} op_t;

	typedef enum logic [1:0] {
		STAT_OK    = 2'd0,
		STAT_FULL  = 2'd1,
		STAT_EMPTY = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_POP,
		S_SCAN,
		S_SFIN
	} state_t;

	typedef enum logic [2:0] {
		ACT_NONE,
		ACT_PUSH_FRONT,
		ACT_PUSH_BACK,
		ACT_POP_FRONT,
		ACT_POP_BACK,
		ACT_SCAN
	} act_t;

	typedef enum logic [1:0] {
		RES_NONE,
		RES_PLAIN,
		RES_POP,
		RES_SEARCH
	} res_t;

	// Controller to datapath.
	typedef struct packed {
		logic    load;
		act_t    act;
		res_t    res;
		status_t res_status;
	} cmd_t;

	// Datapath to controller.
	typedef struct packed {
		logic [2:0] opcode;
		logic       empty;
		logic       full;
		logic       scan_last;
		logic       out_free;
	} sts_t;

	// Effective limit: the configured capacity, but never more than the store holds.
	function automatic logic [CNT_W-1:0] limit_of(logic [CNT_W-1:0] cap);
		logic [CNT_W-1:0] lim;
		lim = cap;
		if (int'(cap) > DEPTH) lim = CNT_W'(DEPTH);
		return lim;
	endfunction

	// Store slot that lies a given distance behind the head, wrapping at DEPTH.
	function automatic logic [AW-1:0] slot_at(logic [AW-1:0] head, logic [CNT_W-1:0] off);
		logic [SW-1:0] sum;
		sum = SW'(head) + SW'(off);
		if (sum >= SW'(DEPTH)) sum = sum - SW'(DEPTH);
		return AW'(sum);
	endfunction

	function automatic logic [AW-1:0] head_dec(logic [AW-1:0] head);
		logic [AW-1:0] r;
		r = (head == '0) ? AW'(DEPTH - 1) : head - AW'(1);
		return r;
	endfunction

	function automatic logic [AW-1:0] head_inc(logic [AW-1:0] head);
		logic [AW-1:0] r;
		r = (head == AW'(DEPTH - 1)) ? '0 : head + AW'(1);
		return r;
	endfunction

endpackage

/* rtl/double_ended_queue_with_search.sv */
// Top level of the bounded double-ended queue with key search.
// Joins deqs_ctrl and deqs_dp and holds the capacity register behind the APB port.
//
// Input beats (s_*) carry one operation each: s_tuser holds the opcode (push front, push
// back, pop front, pop back, search) and s_tdata the key. Each accepted beat yields exactly
// one output beat (m_*) with status in m_tuser and popped value, found flag and occupancy
// in m_tdata. The queue handles one operation at a time; a beat is accepted in the idle
// state while the result register is empty or being drained. A push, an unused opcode or an
// operation on an empty queue is answered from the execute state, a pop after one entry RAM
// read, and a search after reading one entry per cycle through the single RAM read port.
// The block returns to idle as the result is registered and takes no new beat before that.
// Reset empties the queue and sets capacity to 64; the entry RAM itself is not cleared.
// If the receiver stalls, the result holds in m_tdata/m_tuser and s_tready stays low.
// Capacity sits at byte address 0; the user must write it only while the block is idle,
// as the block itself does not enforce this.
module double_ended_queue_with_search (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [31:0]                   s_tdata,  // [31:0] key_value
	input  logic [2:0]                    s_tuser,  // [2:0] opcode
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [39:0]                   m_tdata,  // [31:0] popped_value, [32] key_found,
	                                                 // [39:33] occupancy
	output logic [1:0]                    m_tuser,  // [1:0] status
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [deqs_pkg::PADDR_W-1:0]  paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready
);

	logic [deqs_pkg::CNT_W-1:0] capacity_q;
	deqs_pkg::cmd_t             cmd;
	deqs_pkg::sts_t             sts;
	logic                       out_found;
	logic [deqs_pkg::KEY_W-1:0] out_popped;
	logic [deqs_pkg::CNT_W-1:0] out_occupancy;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) capacity_q <= deqs_pkg::CAPACITY_RESET;
		else if (psel && penable && pwrite && paddr == deqs_pkg::ADDR_CAPACITY)
			capacity_q <= pwdata[deqs_pkg::CNT_W-1:0];
	end

	assign prdata = (paddr == deqs_pkg::ADDR_CAPACITY) ? 32'(capacity_q) : '0;

	deqs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	deqs_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_opcode     (s_tuser),
		.in_key        (s_tdata),
		.capacity      (capacity_q),
		.cmd           (cmd),
		.sts           (sts),
		.out_valid     (m_tvalid),
		.out_ready     (m_tready),
		.out_status    (m_tuser),
		.out_popped    (out_popped),
		.out_found     (out_found),
		.out_occupancy (out_occupancy)
	);

	assign m_tdata = {out_occupancy, out_found, out_popped};

endmodule

/* rtl/deqs_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// Self-contained; holds the queue entries.
module deqs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic                                   re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) mem_q[waddr] <= wdata;
		if (re) rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

/* rtl/deqs_ctrl.sv */
// Controller state machine of the deque: sequences push, pop and search.
// Depends on deqs_pkg; drives the datapath through cmd_t and watches sts_t.
module deqs_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  deqs_pkg::sts_t  sts,
	output deqs_pkg::cmd_t  cmd
);

	deqs_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= deqs_pkg::S_IDLE;
		else state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			deqs_pkg::S_IDLE: begin
				if (in_valid && sts.out_free) state_d = deqs_pkg::S_EXEC;
			end
			deqs_pkg::S_EXEC: begin
				state_d = deqs_pkg::S_IDLE;
				case (sts.opcode) inside
					deqs_pkg::OP_POP_FRONT, deqs_pkg::OP_POP_BACK: begin
						if (!sts.empty) state_d = deqs_pkg::S_POP;
					end
					deqs_pkg::OP_SEARCH: begin
						if (!sts.empty)
							state_d = sts.scan_last ? deqs_pkg::S_SFIN : deqs_pkg::S_SCAN;
					end
					default: state_d = deqs_pkg::S_IDLE;
				endcase
			end
			deqs_pkg::S_POP: state_d = deqs_pkg::S_IDLE;
			deqs_pkg::S_SCAN: begin
				if (sts.scan_last) state_d = deqs_pkg::S_SFIN;
			end
			deqs_pkg::S_SFIN: state_d = deqs_pkg::S_IDLE;
			default: state_d = deqs_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		in_ready = 1'b0;
		cmd.load = 1'b0;
		cmd.act = deqs_pkg::ACT_NONE;
		cmd.res = deqs_pkg::RES_NONE;
		cmd.res_status = deqs_pkg::STAT_OK;
		unique case (state_q)
			deqs_pkg::S_IDLE: begin
				in_ready = sts.out_free;
				cmd.load = in_valid && sts.out_free;
			end
			deqs_pkg::S_EXEC: begin
				case (sts.opcode) inside
					deqs_pkg::OP_PUSH_FRONT, deqs_pkg::OP_PUSH_BACK: begin
						cmd.res = deqs_pkg::RES_PLAIN;
						if (sts.full) cmd.res_status = deqs_pkg::STAT_FULL;
						else if (sts.opcode == deqs_pkg::OP_PUSH_FRONT)
							cmd.act = deqs_pkg::ACT_PUSH_FRONT;
						else cmd.act = deqs_pkg::ACT_PUSH_BACK;
					end
					deqs_pkg::OP_POP_FRONT, deqs_pkg::OP_POP_BACK: begin
						if (sts.empty) begin
							cmd.res = deqs_pkg::RES_PLAIN;
							cmd.res_status = deqs_pkg::STAT_EMPTY;
						end else if (sts.opcode == deqs_pkg::OP_POP_FRONT) begin
							cmd.act = deqs_pkg::ACT_POP_FRONT;
						end else begin
							cmd.act = deqs_pkg::ACT_POP_BACK;
						end
					end
					deqs_pkg::OP_SEARCH: begin
						if (sts.empty) begin
							cmd.res = deqs_pkg::RES_PLAIN;
							cmd.res_status = deqs_pkg::STAT_EMPTY;
						end else begin
							cmd.act = deqs_pkg::ACT_SCAN;
						end
					end
					// Unused opcodes complete at once with nothing changed.
					default: cmd.res = deqs_pkg::RES_PLAIN;
				endcase
			end
			deqs_pkg::S_POP: cmd.res = deqs_pkg::RES_POP;
			deqs_pkg::S_SCAN: cmd.act = deqs_pkg::ACT_SCAN;
			deqs_pkg::S_SFIN: cmd.res = deqs_pkg::RES_SEARCH;
			default: cmd.res = deqs_pkg::RES_NONE;
		endcase
	end

endmodule

/* rtl/deqs_dp.sv */
// Datapath of the deque: head and count registers, entry RAM, search compare, result register.
// Depends on deqs_pkg, deqs_ram and the assertion macros header.
`include "double_ended_queue_with_search_macros.svh"

module deqs_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [2:0]                    in_opcode,
	input  logic [deqs_pkg::KEY_W-1:0]    in_key,
	input  logic [deqs_pkg::CNT_W-1:0]    capacity,
	input  deqs_pkg::cmd_t                cmd,
	output deqs_pkg::sts_t                sts,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [1:0]                    out_status,
	output logic [deqs_pkg::KEY_W-1:0]    out_popped,
	output logic                          out_found,
	output logic [deqs_pkg::CNT_W-1:0]    out_occupancy
);

	logic [2:0]                  op_q;
	logic [deqs_pkg::KEY_W-1:0]  key_q;
	logic [deqs_pkg::AW-1:0]     head_q, head_d;
	logic [deqs_pkg::CNT_W-1:0]  count_q, count_d;
	logic [deqs_pkg::CNT_W-1:0]  scan_k_q;
	logic                        found_q;
	logic                        rd_pend_s1;

	logic                        ram_we, ram_re;
	logic [deqs_pkg::AW-1:0]     ram_waddr, ram_raddr;
	logic [deqs_pkg::KEY_W-1:0]  ram_rdata;
	logic                        match;
	logic                        res_load;

	logic                        out_valid_q;
	logic [1:0]                  out_status_q;
	logic [deqs_pkg::KEY_W-1:0]  out_popped_q;
	logic                        out_found_q;
	logic [deqs_pkg::CNT_W-1:0]  out_occ_q;

	always_comb begin
		head_d = head_q;
		count_d = count_q;
		ram_we = 1'b0;
		ram_waddr = head_q;
		ram_re = 1'b0;
		ram_raddr = head_q;
		case (cmd.act)
			deqs_pkg::ACT_PUSH_FRONT: begin
				head_d = deqs_pkg::head_dec(head_q);
				count_d = count_q + deqs_pkg::CNT_W'(1);
				ram_we = 1'b1;
				ram_waddr = head_d;
			end
			deqs_pkg::ACT_PUSH_BACK: begin
				count_d = count_q + deqs_pkg::CNT_W'(1);
				ram_we = 1'b1;
				ram_waddr = deqs_pkg::slot_at(head_q, count_q);
			end
			deqs_pkg::ACT_POP_FRONT: begin
				head_d = deqs_pkg::head_inc(head_q);
				count_d = count_q - deqs_pkg::CNT_W'(1);
				ram_re = 1'b1;
			end
			deqs_pkg::ACT_POP_BACK: begin
				count_d = count_q - deqs_pkg::CNT_W'(1);
				ram_re = 1'b1;
				ram_raddr = deqs_pkg::slot_at(head_q, count_d);
			end
			deqs_pkg::ACT_SCAN: begin
				ram_re = 1'b1;
				ram_raddr = deqs_pkg::slot_at(head_q, scan_k_q);
			end
			default: ;
		endcase
	end

	deqs_ram #(
		.WIDTH(deqs_pkg::KEY_W),
		.DEPTH(deqs_pkg::DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (key_q),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// A scan read issued last cycle has its data on the RAM output now.
	assign match = rd_pend_s1 && (ram_rdata == key_q);
	assign res_load = (cmd.res != deqs_pkg::RES_NONE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			count_q <= '0;
			scan_k_q <= '0;
			found_q <= 1'b0;
			rd_pend_s1 <= 1'b0;
		end else begin
			head_q <= head_d;
			count_q <= count_d;
			rd_pend_s1 <= (cmd.act == deqs_pkg::ACT_SCAN);
			if (cmd.load) begin
				scan_k_q <= '0;
				found_q <= 1'b0;
			end else begin
				if (cmd.act == deqs_pkg::ACT_SCAN) scan_k_q <= scan_k_q + deqs_pkg::CNT_W'(1);
				if (match) found_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q <= in_opcode;
			key_q <= in_key;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (res_load) out_valid_q <= 1'b1;
		else if (out_ready) out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			out_status_q <= cmd.res_status;
			out_occ_q <= count_d;
			out_popped_q <= (cmd.res == deqs_pkg::RES_POP) ? ram_rdata : '0;
			out_found_q <= (cmd.res == deqs_pkg::RES_SEARCH) && (found_q || match);
		end
	end

	assign sts.opcode = op_q;
	assign sts.empty = (count_q == '0);
	assign sts.full = (count_q >= deqs_pkg::limit_of(capacity));
	assign sts.scan_last = (scan_k_q == count_q - deqs_pkg::CNT_W'(1));
	assign sts.out_free = !out_valid_q || out_ready;

	assign out_valid = out_valid_q;
	assign out_status = out_status_q;
	assign out_popped = out_popped_q;
	assign out_found = out_found_q;
	assign out_occupancy = out_occ_q;

	`DEQS_ASSERT_NOW(a_no_result_overwrite, clk, arst_n, res_load, !out_valid_q || out_ready, "result loaded over a beat not yet taken")
	`DEQS_ASSERT_NEXT(a_push_grows, clk, arst_n, cmd.act == deqs_pkg::ACT_PUSH_FRONT || cmd.act == deqs_pkg::ACT_PUSH_BACK, count_q == $past(count_q) + deqs_pkg::CNT_W'(1), "push did not raise the count")
	`DEQS_ASSERT_NOW(a_count_bounded, clk, arst_n, 1'b1, int'(count_q) <= deqs_pkg::DEPTH, "entry count beyond store depth")

endmodule
